@@ design/nhcs_pkg.sv @@
`default_nettype none
package nhcs_pkg;

  // Largest map radius the walk supports; the controller clamps the map radius to it.
  localparam int MAX_MAP_RADIUS = 15;

  // Port field widths.
  localparam int PT_W       = 32;
  localparam int MD_W       = 31;
  localparam int CR_W       = 31;
  localparam int MR_W       = 4;
  localparam int OUT_IDX_W  = 10;
  localparam int OUT_QR_W   = 5;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_CELL_RADIUS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAP_RADIUS  = 2'd1;

  localparam logic [CR_W-1:0] CELL_RADIUS_RESET = 31'd65536;

  // Walk counters.
  localparam int QW    = $clog2(MAX_MAP_RADIUS + 1) + 1;
  localparam int K_W   = $clog2(2 * MAX_MAP_RADIUS + 1) + 1;
  localparam int CELLS = 3 * MAX_MAP_RADIUS * (MAX_MAP_RADIUS + 1) + 1;
  localparam int IDX_W = $clog2(CELLS);

  // Datapath widths; coordinates are in doubled Q16.16 units, sqrt(3) is Q1.30.
  localparam int SQ3_W   = 31;
  localparam logic [SQ3_W-1:0] SQRT3_Q30 = 31'd1859775393;
  localparam int PROD_W  = CR_W + SQ3_W;
  localparam int H_FRAC  = 30;
  localparam logic [PROD_W-1:0] H_ROUND = {{(PROD_W - H_FRAC){1'b0}}, 1'b1, {(H_FRAC - 1){1'b0}}};
  localparam int H_W     = 32;
  localparam int R3_W    = CR_W + 2;
  localparam int PX_W    = PT_W + 1;
  localparam int LIM_W   = MD_W + 1;
  localparam int LIMSQ_W = 2 * LIM_W;
  localparam int CX_W    = H_W + 1 + K_W;
  localparam int DX_W    = CX_W + 1;
  localparam int MAG_W   = DX_W;
  localparam int LO_W    = (MAG_W + 1) / 2;
  localparam int HI_W    = MAG_W - LO_W;
  localparam int SQ_W    = 2 * MAG_W;
  localparam int SUM_W   = SQ_W + 1;

  typedef struct packed {
    logic [CR_W-1:0] cell_radius;
    logic [MR_W-1:0] map_radius;
  } cfg_t;

  // Controller to datapath.
  typedef struct packed {
    logic             start;
    logic             setup;
    logic             round;
    logic             issue;
    logic             load_out;
    logic [QW-1:0]    q;
    logic [QW-1:0]    r;
    logic [IDX_W-1:0] idx;
  } cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic busy;
    logic out_hold;
  } stat_t;

endpackage
`default_nettype wire

@@ design/nhcs_if.sv @@
`default_nettype none
interface nhcs_query_if;
  logic                            valid;
  logic                            ready;
  logic signed [nhcs_pkg::PT_W-1:0] point_x;
  logic signed [nhcs_pkg::PT_W-1:0] point_z;
  logic [nhcs_pkg::MD_W-1:0]        max_distance;

  modport source (output valid, output point_x, output point_z, output max_distance,
                  input ready);
  modport sink (input valid, input point_x, input point_z, input max_distance,
                output ready);
endinterface

interface nhcs_result_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  found;
  logic [nhcs_pkg::OUT_IDX_W-1:0]        cell_index;
  logic signed [nhcs_pkg::OUT_QR_W-1:0]  cell_q;
  logic signed [nhcs_pkg::OUT_QR_W-1:0]  cell_r;

  modport source (output valid, output found, output cell_index, output cell_q,
                  output cell_r, input ready);
  modport sink (input valid, input found, input cell_index, input cell_q, input cell_r,
                output ready);
endinterface

interface nhcs_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [nhcs_pkg::CFG_IDX_W-1:0]    index;
  logic [nhcs_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

@@ design/nearest_hex_cell_search.sv @@
// Nearest hexagonal cell search.
//
// A request on the query channel carries a point (point_x, point_z) and an
// exclusive distance limit, all Q16.16. The block walks every cell of a hex
// map of radius map_radius (q rising, then r rising) and returns on the
// result channel the first cell whose distance to the point is below both
// the limit and the best distance seen so far, or found = 0 with zeroed
// fields. Distances are compared as exact squares, so ties go to the earlier
// cell of the walk.
//
// The configuration channel writes cell_radius (index 0) and map_radius
// (index 1); it is always ready. The user must write it only while no
// query is open; the block itself does not enforce this. The walk takes
// one cell per cycle over all N = 3M(M+1) + 1 cells; the setup states
// S_SETUP and S_ROUND form the cell step, the five-stage pipeline drains,
// and then the result is loaded and the block returns to idle. The next
// query is accepted only in idle, once the last one is through.
// The result is held in an output register, so a stalled receiver only
// delays the end of the next query. Reset restores cell_radius = 1.0 and
// map_radius = 0 and empties the output register.
`default_nettype none
module nearest_hex_cell_search (
  input wire logic      clk,
  input wire logic      rst,
  nhcs_query_if.sink    query,
  nhcs_result_if.source result,
  nhcs_cfg_if.sink      cfg
);

  nhcs_pkg::cfg_t  cfg_regs;
  nhcs_pkg::cmd_t  cmd;
  nhcs_pkg::stat_t stat;

  // Configuration registers.
  nhcs_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (cfg.valid),
    .wr_ready (cfg.ready),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .cfg      (cfg_regs)
  );

  // The controller sequences setup, the cell walk, the drain and the result load.
  nhcs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (query.valid),
    .in_ready   (query.ready),
    .map_radius (cfg_regs.map_radius),
    .stat       (stat),
    .cmd        (cmd)
  );

  // The datapath computes squared distances and holds the best cell and the result.
  nhcs_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .cell_radius  (cfg_regs.cell_radius),
    .point_x      (query.point_x),
    .point_z      (query.point_z),
    .max_distance (query.max_distance),
    .out_ready    (result.ready),
    .stat         (stat),
    .out_valid    (result.valid),
    .found        (result.found),
    .cell_index   (result.cell_index),
    .cell_q       (result.cell_q),
    .cell_r       (result.cell_r)
  );

endmodule
`default_nettype wire

@@ design/nhcs_regs.sv @@
`default_nettype none
module nhcs_regs (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             wr_valid,
  output logic                                  wr_ready,
  input  wire logic [nhcs_pkg::CFG_IDX_W-1:0]   wr_index,
  input  wire logic [nhcs_pkg::CFG_DATA_W-1:0]  wr_data,
  output nhcs_pkg::cfg_t                        cfg
);

  assign wr_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cell_radius <= nhcs_pkg::CELL_RADIUS_RESET;
      cfg.map_radius  <= '0;
    end else if (wr_valid) begin
      case (wr_index)
        nhcs_pkg::REG_CELL_RADIUS: cfg.cell_radius <= wr_data[nhcs_pkg::CR_W-1:0];
        nhcs_pkg::REG_MAP_RADIUS:  cfg.map_radius  <= wr_data[nhcs_pkg::MR_W-1:0];
        default: begin
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/nhcs_ctrl.sv @@
`default_nettype none
module nhcs_ctrl (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [nhcs_pkg::MR_W-1:0]   map_radius,
  input  wire nhcs_pkg::stat_t             stat,
  output nhcs_pkg::cmd_t                   cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SETUP,
    S_ROUND,
    S_RUN,
    S_DRAIN,
    S_DONE
  } state_t;

  state_t state;
  logic signed [nhcs_pkg::QW-1:0] q;
  logic signed [nhcs_pkg::QW-1:0] r;
  logic [nhcs_pkg::IDX_W-1:0]     idx;
  logic signed [nhcs_pkg::QW-1:0] m;
  logic signed [nhcs_pkg::QW-1:0] q_inc;
  logic signed [nhcs_pkg::QW-1:0] row_end;
  logic signed [nhcs_pkg::QW-1:0] next_row_start;

  // First and last r of row q in a hexagon of radius mm.
  function automatic logic signed [nhcs_pkg::QW-1:0] row_min(
      input logic signed [nhcs_pkg::QW-1:0] qq, input logic signed [nhcs_pkg::QW-1:0] mm);
    if (qq < 0) row_min = -qq - mm;
    else row_min = -mm;
  endfunction

  function automatic logic signed [nhcs_pkg::QW-1:0] row_max(
      input logic signed [nhcs_pkg::QW-1:0] qq, input logic signed [nhcs_pkg::QW-1:0] mm);
    if (qq < 0) row_max = mm;
    else row_max = mm - qq;
  endfunction

  always_comb begin
    if (int'(map_radius) > nhcs_pkg::MAX_MAP_RADIUS) begin
      m = nhcs_pkg::QW'(nhcs_pkg::MAX_MAP_RADIUS);
    end else begin
      m = nhcs_pkg::QW'(map_radius);
    end
    q_inc          = q + nhcs_pkg::QW'(1);
    row_end        = row_max(q, m);
    next_row_start = row_min(q_inc, m);
  end

  assign in_ready     = (state == S_IDLE);
  assign cmd.start    = in_valid && (state == S_IDLE);
  assign cmd.setup    = (state == S_SETUP);
  assign cmd.round    = (state == S_ROUND);
  assign cmd.issue    = (state == S_RUN);
  assign cmd.load_out = (state == S_DONE) && !stat.out_hold;
  assign cmd.q        = q;
  assign cmd.r        = r;
  assign cmd.idx      = idx;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      q     <= '0;
      r     <= '0;
      idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_SETUP;
        end
        S_SETUP: begin
          state <= S_ROUND;
        end
        S_ROUND: begin
          q     <= -m;
          r     <= row_min(-m, m);
          idx   <= '0;
          state <= S_RUN;
        end
        S_RUN: begin
          if (r == row_end) begin
            if (q == m) begin
              state <= S_DRAIN;
            end else begin
              q   <= q_inc;
              r   <= next_row_start;
              idx <= idx + nhcs_pkg::IDX_W'(1);
            end
          end else begin
            r   <= r + nhcs_pkg::QW'(1);
            idx <= idx + nhcs_pkg::IDX_W'(1);
          end
        end
        S_DRAIN: begin
          if (!stat.busy) state <= S_DONE;
        end
        S_DONE: begin
          if (!stat.out_hold) state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
`default_nettype wire

@@ design/nhcs_dp.sv @@
`default_nettype none
module nhcs_dp (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire nhcs_pkg::cmd_t                      cmd,
  input  wire logic [nhcs_pkg::CR_W-1:0]           cell_radius,
  input  wire logic signed [nhcs_pkg::PT_W-1:0]    point_x,
  input  wire logic signed [nhcs_pkg::PT_W-1:0]    point_z,
  input  wire logic [nhcs_pkg::MD_W-1:0]           max_distance,
  input  wire logic                                out_ready,
  output nhcs_pkg::stat_t                          stat,
  output logic                                     out_valid,
  output logic                                     found,
  output logic [nhcs_pkg::OUT_IDX_W-1:0]           cell_index,
  output logic signed [nhcs_pkg::OUT_QR_W-1:0]     cell_q,
  output logic signed [nhcs_pkg::OUT_QR_W-1:0]     cell_r
);

  localparam int NS = 5;

  // Per-query constants.
  logic signed [nhcs_pkg::PX_W-1:0]   px2;
  logic signed [nhcs_pkg::PX_W-1:0]   pz2;
  logic [nhcs_pkg::LIM_W-1:0]         lim2;
  logic [nhcs_pkg::LIMSQ_W-1:0]       limsq;
  logic [nhcs_pkg::PROD_W-1:0]        prod_h;
  logic [nhcs_pkg::PROD_W-1:0]        hsum;
  logic [nhcs_pkg::H_W-1:0]           h;
  logic [nhcs_pkg::R3_W-1:0]          r3;

  // Pipeline.
  logic [NS:1]                        vld;
  logic [nhcs_pkg::QW-1:0]            tag_q [1:NS];
  logic [nhcs_pkg::QW-1:0]            tag_r [1:NS];
  logic [nhcs_pkg::IDX_W-1:0]         tag_idx [1:NS];
  logic signed [nhcs_pkg::K_W-1:0]    k;
  logic signed [nhcs_pkg::CX_W-1:0]   cx2;
  logic signed [nhcs_pkg::CX_W-1:0]   cz2;
  logic signed [nhcs_pkg::DX_W-1:0]   dx;
  logic signed [nhcs_pkg::DX_W-1:0]   dz;
  logic [nhcs_pkg::MAG_W-1:0]         mx;
  logic [nhcs_pkg::MAG_W-1:0]         mz;
  logic [2*nhcs_pkg::HI_W-1:0]        xhh;
  logic [2*nhcs_pkg::HI_W-1:0]        zhh;
  logic [nhcs_pkg::HI_W+nhcs_pkg::LO_W-1:0] xhl;
  logic [nhcs_pkg::HI_W+nhcs_pkg::LO_W-1:0] zhl;
  logic [2*nhcs_pkg::LO_W-1:0]        xll;
  logic [2*nhcs_pkg::LO_W-1:0]        zll;
  logic [nhcs_pkg::SQ_W-1:0]          sqx;
  logic [nhcs_pkg::SQ_W-1:0]          sqz;
  logic [nhcs_pkg::SUM_W-1:0]         sum;

  // Best cell so far.
  logic [nhcs_pkg::SUM_W-1:0]         best;
  logic                               best_found;
  logic [nhcs_pkg::IDX_W-1:0]         best_idx;
  logic [nhcs_pkg::QW-1:0]            best_q;
  logic [nhcs_pkg::QW-1:0]            best_r;

  assign limsq = lim2 * lim2;
  assign hsum  = prod_h + nhcs_pkg::H_ROUND;
  assign k     = (nhcs_pkg::K_W'($signed(cmd.q)) <<< 1) + nhcs_pkg::K_W'($signed(cmd.r));
  assign dx    = nhcs_pkg::DX_W'(px2) - nhcs_pkg::DX_W'(cx2);
  assign dz    = nhcs_pkg::DX_W'(pz2) - nhcs_pkg::DX_W'(cz2);

  assign stat.busy     = |vld;
  assign stat.out_hold = out_valid && !out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      px2  <= {point_x, 1'b0};
      pz2  <= {point_z, 1'b0};
      lim2 <= {max_distance, 1'b0};
    end
    if (cmd.setup) begin
      prod_h <= cell_radius * nhcs_pkg::SQRT3_Q30;
      r3     <= nhcs_pkg::R3_W'({cell_radius, 1'b0}) + nhcs_pkg::R3_W'(cell_radius);
    end
    // The cell step along x, rounded half up to Q16.16.
    if (cmd.round) begin
      h <= hsum[nhcs_pkg::H_FRAC +: nhcs_pkg::H_W];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[NS-1:1], cmd.issue};
    end
  end

  always_ff @(posedge clk) begin
    tag_q[1]   <= cmd.q;
    tag_r[1]   <= cmd.r;
    tag_idx[1] <= cmd.idx;
    for (int i = 2; i <= NS; i++) begin
      tag_q[i]   <= tag_q[i-1];
      tag_r[i]   <= tag_r[i-1];
      tag_idx[i] <= tag_idx[i-1];
    end

    // Cell centre in doubled units.
    cx2 <= $signed({1'b0, h}) * k;
    cz2 <= $signed({1'b0, r3}) * $signed(cmd.r);

    // Offsets to the query point, as magnitudes.
    mx <= dx[nhcs_pkg::DX_W-1] ? $unsigned(-dx) : $unsigned(dx);
    mz <= dz[nhcs_pkg::DX_W-1] ? $unsigned(-dz) : $unsigned(dz);

    // Squares split into half-width partial products.
    xhh <= mx[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W] * mx[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W];
    xhl <= mx[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W] * mx[nhcs_pkg::LO_W-1:0];
    xll <= mx[nhcs_pkg::LO_W-1:0] * mx[nhcs_pkg::LO_W-1:0];
    zhh <= mz[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W] * mz[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W];
    zhl <= mz[nhcs_pkg::MAG_W-1 -: nhcs_pkg::HI_W] * mz[nhcs_pkg::LO_W-1:0];
    zll <= mz[nhcs_pkg::LO_W-1:0] * mz[nhcs_pkg::LO_W-1:0];

    sqx <= (nhcs_pkg::SQ_W'(xhh) << (2 * nhcs_pkg::LO_W))
         + (nhcs_pkg::SQ_W'(xhl) << (nhcs_pkg::LO_W + 1))
         + nhcs_pkg::SQ_W'(xll);
    sqz <= (nhcs_pkg::SQ_W'(zhh) << (2 * nhcs_pkg::LO_W))
         + (nhcs_pkg::SQ_W'(zhl) << (nhcs_pkg::LO_W + 1))
         + nhcs_pkg::SQ_W'(zll);

    sum <= nhcs_pkg::SUM_W'(sqx) + nhcs_pkg::SUM_W'(sqz);
  end

  // Strict compare keeps the earlier cell on a tie.
  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      best       <= nhcs_pkg::SUM_W'(limsq);
      best_found <= 1'b0;
      best_idx   <= '0;
      best_q     <= '0;
      best_r     <= '0;
    end else if (vld[NS] && (sum < best)) begin
      best       <= sum;
      best_found <= 1'b1;
      best_idx   <= tag_idx[NS];
      best_q     <= tag_q[NS];
      best_r     <= tag_r[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      found      <= best_found;
      cell_index <= nhcs_pkg::OUT_IDX_W'(best_idx);
      cell_q     <= nhcs_pkg::OUT_QR_W'($signed(best_q));
      cell_r     <= nhcs_pkg::OUT_QR_W'($signed(best_r));
    end
  end

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int          CYCLE_LIMIT  = 5_000_000;
  localparam int          HOLD_CYCLES  = 3000;
  localparam int          TAIL_CYCLES  = 40;
  localparam int          REPORT_LIMIT = 10;
  localparam int          NUM_PHASES   = 13;
  localparam logic signed [nhcs_pkg::PT_W-1:0] PT_MAX = {1'b0, {(nhcs_pkg::PT_W - 1){1'b1}}};
  localparam logic signed [nhcs_pkg::PT_W-1:0] PT_MIN = {1'b1, {(nhcs_pkg::PT_W - 1){1'b0}}};
  localparam logic [nhcs_pkg::MD_W-1:0]        MD_MAX = '1;
  // Register indexes past the end of the register list. The block must
  // ignore writes to them.
  localparam logic [nhcs_pkg::CFG_IDX_W-1:0]   REG_SPARE_A = 2'd2;
  localparam logic [nhcs_pkg::CFG_IDX_W-1:0]   REG_SPARE_B = 2'd3;

  typedef struct packed {
    logic                                 found;
    logic [nhcs_pkg::OUT_IDX_W-1:0]       cell_index;
    logic signed [nhcs_pkg::OUT_QR_W-1:0] cell_q;
    logic signed [nhcs_pkg::OUT_QR_W-1:0] cell_r;
  } hit_t;

  // Holds its own copy of the two registers and the queue of answers that
  // are still owed by the block.
  class hex_search_board;
    logic [nhcs_pkg::CR_W-1:0] cell_radius;
    logic [nhcs_pkg::MR_W-1:0] map_radius;
    hit_t                      awaited[$];
    int unsigned               mismatches;

    function new();
      cell_radius = nhcs_pkg::CELL_RADIUS_RESET;
      map_radius  = '0;
      mismatches  = 0;
    endfunction

    function void write_reg(logic [nhcs_pkg::CFG_IDX_W-1:0] idx,
                            logic [nhcs_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        nhcs_pkg::REG_CELL_RADIUS: cell_radius = data[nhcs_pkg::CR_W-1:0];
        nhcs_pkg::REG_MAP_RADIUS:  map_radius  = data[nhcs_pkg::MR_W-1:0];
        default: ;
      endcase
    endfunction

    // Horizontal step between cell centres (radius * sqrt(3)), rounded half up to Q16.16.
    function longint hex_step();
      logic [63:0] prod;
      prod = 64'(cell_radius) * 64'(nhcs_pkg::SQRT3_Q30) + (64'd1 << 29);
      return longint'(prod >> 30);
    endfunction

    // Walks the map in the block's order. It keeps the first cell whose exact
    // squared distance, in doubled units, beats both the limit and every
    // earlier cell.
    function hit_t nearest_cell(logic signed [nhcs_pkg::PT_W-1:0] px,
                                logic signed [nhcs_pkg::PT_W-1:0] pz,
                                logic [nhcs_pkg::MD_W-1:0] md);
      longint             h, rad, dx, dz;
      logic signed [127:0] dxw, dzw;
      logic [127:0]       lim, best, dsq;
      int                 m, rlo, rhi;
      int unsigned        idx;
      hit_t               hit;
      hit  = '0;
      h    = hex_step();
      rad  = longint'(cell_radius);
      lim  = 128'({md, 1'b0});
      best = lim * lim;
      m    = (int'(map_radius) > nhcs_pkg::MAX_MAP_RADIUS) ? nhcs_pkg::MAX_MAP_RADIUS
                                                            : int'(map_radius);
      idx  = 0;
      for (int q = -m; q <= m; q++) begin
        rlo = (-q - m > -m) ? -q - m : -m;
        rhi = (-q + m < m) ? -q + m : m;
        for (int r = rlo; r <= rhi; r++) begin
          dx   = 2 * longint'(px) - h * (2 * q + r);
          dz   = 2 * longint'(pz) - 3 * rad * r;
          dxw  = 128'(dx);
          dzw  = 128'(dz);
          dsq  = dxw * dxw + dzw * dzw;
          if (dsq < best) begin
            best           = dsq;
            hit.found      = 1'b1;
            hit.cell_index = idx[nhcs_pkg::OUT_IDX_W-1:0];
            hit.cell_q     = q[nhcs_pkg::OUT_QR_W-1:0];
            hit.cell_r     = r[nhcs_pkg::OUT_QR_W-1:0];
          end
          idx++;
        end
      end
      return hit;
    endfunction

    function void note_query(logic signed [nhcs_pkg::PT_W-1:0] px,
                             logic signed [nhcs_pkg::PT_W-1:0] pz,
                             logic [nhcs_pkg::MD_W-1:0] md);
      awaited = {awaited, nearest_cell(px, pz, md)};
    endfunction

    function void flag(string what);
      mismatches++;
      if (mismatches <= REPORT_LIMIT) $display("mismatch: %s", what);
    endfunction

    function void check_result(hit_t got);
      hit_t want;
      if (awaited.size() == 0) begin
        flag($sformatf("result with no query outstanding: found=%0b index=%0d q=%0d r=%0d",
                       got.found, got.cell_index, got.cell_q, got.cell_r));
        return;
      end
      want = awaited.pop_front();
      if (got.found !== want.found || got.cell_index !== want.cell_index ||
          got.cell_q !== want.cell_q || got.cell_r !== want.cell_r)
        flag({$sformatf("expected found=%0b index=%0d q=%0d r=%0d, ",
                        want.found, want.cell_index, want.cell_q, want.cell_r),
              $sformatf("got found=%0b index=%0d q=%0d r=%0d",
                        got.found, got.cell_index, got.cell_q, got.cell_r)});
    endfunction

    function int outstanding();
      return awaited.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  nhcs_query_if  query_ch();
  nhcs_result_if result_ch();
  nhcs_cfg_if    cfg_ch();

  nearest_hex_cell_search dut (
    .clk    (clk),
    .rst    (rst),
    .query  (query_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  hex_search_board board = new();

  // The phase loop sets these to switch idling on or off. A stretch with
  // both flags clear runs the channels back to back.
  bit send_gaps    = 1'b1;
  bit take_stalls  = 1'b1;
  // Asks the result side for one long hold-off. The query side keeps
  // offering requests during it, so the block fills up and stops taking them.
  bit hold_request = 1'b0;

  int unsigned cycle_count = 0;

  always #5 clk = ~clk;

  // Safety net: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Saturates a wide coordinate to the Q16.16 range of the port.
  function automatic logic signed [nhcs_pkg::PT_W-1:0] coord(longint v);
    if (v > 64'sd2147483647) return PT_MAX;
    if (v < -64'sd2147483648) return PT_MIN;
    return v[nhcs_pkg::PT_W-1:0];
  endfunction

  // Centre of cell (q, r) under the current registers, in plain Q16.16. It
  // is truncated when the doubled value is odd.
  function automatic void center_of(int q, int r, output longint cx, output longint cz);
    cx = board.hex_step() * (2 * q + r) / 2;
    cz = 3 * longint'(board.cell_radius) * r / 2;
  endfunction

  // Offers one query, after a random gap if gaps are on. The expected answer
  // is noted at the edge that accepts the query. The valid line is left high,
  // so that the next query can follow straight on.
  task automatic send_query(logic signed [nhcs_pkg::PT_W-1:0] px,
                            logic signed [nhcs_pkg::PT_W-1:0] pz,
                            logic [nhcs_pkg::MD_W-1:0] md);
    int gap;
    gap = send_gaps ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      query_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    query_ch.valid        <= 1'b1;
    query_ch.point_x      <= px;
    query_ch.point_z      <= pz;
    query_ch.max_distance <= md;
    do @(posedge clk); while (query_ch.ready !== 1'b1);
    board.note_query(px, pz, md);
  endtask

  // Stops offering queries and waits until every answer owed has arrived.
  task automatic drain();
    query_ch.valid <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  // The channel is left idle after each write.
  task automatic cfg_write(logic [nhcs_pkg::CFG_IDX_W-1:0] idx,
                           logic [nhcs_pkg::CFG_DATA_W-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (cfg_ch.ready !== 1'b1);
    board.write_reg(idx, data);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  // Result side. It draws a stall before each result, or takes the long
  // hold-off when one has been asked for. It then raises ready and checks
  // the result at the edge that accepts it.
  initial begin
    int   stall;
    hit_t got;
    result_ch.ready <= 1'b0;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      stall = take_stalls ? $urandom_range(0, 7) : 0;
      if (hold_request) begin
        stall        = HOLD_CYCLES;
        hold_request = 1'b0;
      end
      if (stall > 0) begin
        result_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      got = {result_ch.found, result_ch.cell_index, result_ch.cell_q, result_ch.cell_r};
      board.check_result(got);
    end
  end

  // Query side. It also owns the register writes and the verdict.
  initial begin
    longint                           cx, cz, cx2, cz2, span, mdl;
    int                               m, q, r, rlo, rhi, n_items, kind;
    bit                               mid_drain;
    logic [nhcs_pkg::CFG_DATA_W-1:0]  cr_data, mr_data;
    logic signed [nhcs_pkg::PT_W-1:0] px, pz;
    logic [nhcs_pkg::MD_W-1:0]        md;

    query_ch.valid        <= 1'b0;
    query_ch.point_x      <= '0;
    query_ch.point_z      <= '0;
    query_ch.max_distance <= '0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= '0;
    cfg_ch.data           <= '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Reset registers: a one-cell map of radius 1.0. A zero limit finds
    // nothing. Far corner points lie beyond the largest limit.
    send_query('0, '0, 31'd1);
    send_query('0, '0, '0);
    send_query(PT_MAX, PT_MAX, MD_MAX);
    send_query(PT_MIN, PT_MIN, MD_MAX);
    drain();

    // Junk in the bits above each field must be dropped. Writes to indexes
    // past the register list must change nothing.
    cfg_write(nhcs_pkg::REG_CELL_RADIUS, 32'h8001_0000);
    cfg_write(nhcs_pkg::REG_MAP_RADIUS, 32'hFFFF_FFF3);
    cfg_write(REG_SPARE_A, $urandom);
    cfg_write(REG_SPARE_B, $urandom);

    // Radius 3 map. The first cell of the walk is (-3, 0), with index 0.
    // The last is (3, 0), with index 36.
    center_of(-3, 0, cx, cz);
    send_query(coord(cx), coord(cz), 31'd1);
    center_of(3, 0, cx, cz);
    send_query(coord(cx), coord(cz), 31'd1);
    center_of(3, -3, cx, cz);
    send_query(coord(cx), coord(cz), 31'd1);
    center_of(-3, 3, cx, cz);
    send_query(coord(cx), coord(cz), 31'd1);
    send_query('0, '0, 31'd1);
    // A zero limit, even with the point right on a cell centre.
    send_query('0, '0, '0);
    // One unit off a centre. A limit of one unit misses, because the bound
    // is exclusive. A limit of two units hits.
    send_query(32'sd1, '0, 31'd1);
    send_query(32'sd1, '0, 31'd2);
    // Halfway between (0, 0) and (1, 0). The earlier cell of the walk must win.
    center_of(1, 0, cx, cz);
    send_query(coord(cx / 2), '0, MD_MAX);
    // Extreme coordinates and limits.
    send_query(PT_MAX, PT_MAX, MD_MAX);
    send_query(PT_MIN, PT_MIN, MD_MAX);
    send_query(PT_MAX, PT_MIN, '0);
    send_query(PT_MIN, PT_MAX, 31'd1);
    send_query(-32'sd1, -32'sd1, MD_MAX);
    send_query('0, '0, MD_MAX);
    // Well off the map, with a limit that cannot reach any cell.
    center_of(3, 0, cx, cz);
    send_query(coord(cx + 10 * 65536), '0, 31'd65536);

    // Random phases. Each one starts from an idle block. Large maps get few
    // queries, because every query walks the whole map.
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      mid_drain = 1'b0;
      cr_data   = $urandom;
      mr_data   = $urandom;
      case (ph)
        0: begin
          // Zero cell radius: every centre sits at the origin, so all
          // distances tie.
          cr_data[nhcs_pkg::CR_W-1:0] = '0;
          mr_data[nhcs_pkg::MR_W-1:0] = nhcs_pkg::MR_W'(nhcs_pkg::MAX_MAP_RADIUS);
          n_items = 15;
        end
        1: begin
          cr_data[nhcs_pkg::CR_W-1:0] = '1;
          mr_data[nhcs_pkg::MR_W-1:0] = 4'd2;
          n_items = 60;
          hold_request = 1'b1;
        end
        2: begin
          cr_data[nhcs_pkg::CR_W-1:0] = 31'd1;
          mr_data[nhcs_pkg::MR_W-1:0] = 4'd1;
          n_items = 80;
          mid_drain = 1'b1;
        end
        3: begin
          mr_data[nhcs_pkg::MR_W-1:0] = nhcs_pkg::MR_W'(nhcs_pkg::MAX_MAP_RADIUS);
          n_items = 40;
        end
        4: begin
          cr_data[nhcs_pkg::CR_W-1:0] = '1;
          mr_data[nhcs_pkg::MR_W-1:0] = nhcs_pkg::MR_W'(nhcs_pkg::MAX_MAP_RADIUS);
          n_items = 20;
        end
        5: begin
          cr_data = cr_data >> $urandom_range(8, 20);
          mr_data[nhcs_pkg::MR_W-1:0] = '0;
          n_items = 60;
        end
        default: begin
          cr_data = cr_data >> $urandom_range(0, 24);
          mr_data[nhcs_pkg::MR_W-1:0] = nhcs_pkg::MR_W'($urandom_range(0, 5));
          n_items = 75;
        end
      endcase
      if ($urandom_range(0, 1)) begin
        cfg_write(nhcs_pkg::REG_CELL_RADIUS, cr_data);
        cfg_write(nhcs_pkg::REG_MAP_RADIUS, mr_data);
      end else begin
        cfg_write(nhcs_pkg::REG_MAP_RADIUS, mr_data);
        cfg_write(nhcs_pkg::REG_CELL_RADIUS, cr_data);
      end
      send_gaps   = ($urandom_range(0, 3) != 0);
      take_stalls = ($urandom_range(0, 3) != 0);

      for (int i = 0; i < n_items; i++) begin
        // Once in the run, the query side pauses midway until the block
        // has answered everything.
        if (mid_drain && i == n_items / 2) drain();
        m   = int'(board.map_radius);
        q   = $urandom_range(0, 2 * m) - m;
        rlo = (-q - m > -m) ? -q - m : -m;
        rhi = (-q + m < m) ? -q + m : m;
        r   = rlo + $urandom_range(0, rhi - rlo);
        center_of(q, r, cx, cz);
        span = (longint'(board.cell_radius) >> $urandom_range(0, 6)) + 1;
        kind = $urandom_range(0, 9);
        if (kind < 6) begin
          // Near a cell, with a limit on the scale of the offset, so that
          // the answer can go either way.
          px = coord(cx + longint'($urandom) % (2 * span + 1) - span);
          pz = coord(cz + longint'($urandom) % (2 * span + 1) - span);
          case ($urandom_range(0, 3))
            0: md = nhcs_pkg::MD_W'($urandom_range(0, 3));
            1: md = MD_MAX;
            default: begin
              mdl = longint'($urandom) % (2 * span + 2);
              if (mdl > 64'sh7FFF_FFFF) mdl = 64'sh7FFF_FFFF;
              md = mdl[nhcs_pkg::MD_W-1:0];
            end
          endcase
        end else if (kind < 7) begin
          // Halfway to a neighbor. This often gives an exact tie.
          if ($urandom_range(0, 1)) center_of(q + 1, r, cx2, cz2);
          else center_of(q, r + 1, cx2, cz2);
          px = coord((cx + cx2) / 2);
          pz = coord((cz + cz2) / 2);
          md = MD_MAX;
        end else begin
          px = $urandom;
          pz = $urandom;
          md = $urandom_range(0, 1) ? MD_MAX : nhcs_pkg::MD_W'($urandom);
        end
        send_query(px, pz, md);
      end
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (board.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire
